// ===== sv/c8x_pkg.sv =====
// Package: shared types, constants and font table for the CHIP-8 subset core.
`default_nettype none
package c8x_pkg;
   localparam int MEM_DEPTH_DEF = 4096;
   localparam int SCREEN_WIDTH_DEF = 64;
   localparam int SCREEN_HEIGHT_DEF = 32;
   localparam int FONT_BYTES = 80;
   localparam logic [11:0] PC_RESET = 12'h200;
   localparam logic [15:0] OP_CLS = 16'h00E0;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_EXEC  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      GRP_SYS  = 4'h0,
      GRP_JP   = 4'h1,
      GRP_LD   = 4'h6,
      GRP_ADD  = 4'h7,
      GRP_LDI  = 4'hA,
      GRP_DRW  = 4'hD
   } op_grp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE, ST_ROW_RD,
      ST_ROW_WAIT, ST_LEFT_RD, ST_LEFT_WR, ST_RIGHT_RD, ST_RIGHT_WR, ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] address;
      logic [7:0]  data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [11:0] program_counter;
      logic        collision;
      logic        unknown_opcode;
   } rsp_type;

   function automatic logic [7:0] font_byte(input logic [6:0] idx);
      logic [7:0] f [0:79];
      f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
            8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
            8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
            8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
            8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
            8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
            8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
            8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
      if (idx < 7'(FONT_BYTES)) return f[idx];
      return 8'h00;
   endfunction
endpackage
`default_nettype wire

// ===== sv/c8x_mem.sv =====
// Main memory, swept after reset so every byte reads as font or zero.
`default_nettype none
module c8x_mem
   import c8x_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MEM_DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]                   wr_data,
   input  wire logic [$clog2(MEM_DEPTH)-1:0] rd_addr,
   output logic      [7:0]                   rd_data
);
   localparam int AW = $clog2(MEM_DEPTH);
   localparam int CW = AW + 1;

   logic [7:0]    mem [0:MEM_DEPTH-1];
   logic [CW-1:0] clr_ff;
   logic [7:0]    raw_ff;

   // sweep the memory after reset, loading font and zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (!clr_ff[AW]) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!clr_ff[AW]) begin
         mem[clr_ff[AW-1:0]] <= (clr_ff < CW'(FONT_BYTES)) ?
                                font_byte(clr_ff[6:0]) : 8'h00;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      raw_ff <= mem[rd_addr];
   end

   assign rd_data = raw_ff;
endmodule
`default_nettype wire

// ===== sv/c8x_frame.sv =====
// Frame store, 256 bytes, one read and one write port.
`default_nettype none
module c8x_frame
   import c8x_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       wr_en,
   input  wire logic [7:0] wr_addr,
   input  wire logic [7:0] wr_data,
   input  wire logic [7:0] rd_addr,
   output logic      [7:0] rd_data
);
   logic [7:0] fb [0:255];
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fb[wr_addr] <= wr_data;
      end
      rd_ff <= fb[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

// ===== sv/chip8_core_subset_executor.sv =====
// Top level: CHIP-8 subset core with a sequencer over shared memory ports.
//
//   channel | dir | payload  | handshake
//   req     | in  | req_type | req_valid / req_stall
//   rsp     | out | rsp_type | rsp_valid / rsp_stall
//
// Memory write and frame read go from decode to done; LD/ADD/JP/LDI first
// fetch both opcode bytes. CLS sweeps all 256 frame bytes, one a cycle.
// DRW reads each sprite row, then reads and writes the left frame byte, and
// the right one as well when x is not a multiple of 8, via the frame port.
// After reset the main memory and frame are swept before req is taken.
// req_stall is high whenever an item is in work or a result waits.
`default_nettype none
module chip8_core_subset_executor
   import c8x_pkg::*;
#(
   parameter int MEM_DEPTH     = MEM_DEPTH_DEF,
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int AW = $clog2(MEM_DEPTH);
   localparam int RB = SCREEN_WIDTH / 8;
   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam int CB = $clog2(RB);
   localparam int FW = $clog2(RB * SCREEN_HEIGHT);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [7:0]    vreg_ff [0:15];
   logic [AW-1:0] pc_ff, idx_ff;
   logic [15:0]   op_ff;
   logic [15:0]   op_now;
   logic [3:0]    row_ff;
   logic [FW:0]   clr_ff;
   logic [7:0]    sprite_ff, fbyte_ff;
   logic          hit_ff, unk_ff;
   logic [AW:0]   boot_ff;
   logic          coll_ff;

   logic [AW-1:0] mem_ra;
   logic [7:0]    mem_rd;
   logic          mem_we;
   logic [7:0]    fb_ra, fb_wa, fb_wd, fb_rd;
   logic          fb_we;

   logic [XW-1:0] x_pos;
   logic [2:0]    shft;
   logic [CB-1:0] col, ncol;
   logic [YW-1:0] py;
   logic [7:0]    left_m, right_m, row_base;
   logic [15:0]   sh_wide;

   c8x_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
      .clock, .reset, .wr_en(mem_we), .wr_addr(req_ff.address[AW-1:0]),
      .wr_data(req_ff.data), .rd_addr(mem_ra), .rd_data(mem_rd));

   c8x_frame u_frame (
      .clock, .wr_en(fb_we), .wr_addr(fb_wa), .wr_data(fb_wd),
      .rd_addr(fb_ra), .rd_data(fb_rd));

   // full opcode in decode: low byte straight from the memory port
   assign op_now = {op_ff[15:8], mem_rd};

   // shared shifter for sprite alignment
   assign x_pos    = vreg_ff[op_ff[11:8]][XW-1:0];
   assign shft     = x_pos[2:0];
   assign col      = x_pos[XW-1:3];
   assign ncol     = col + 1'b1;
   assign py       = YW'(vreg_ff[op_ff[7:4]] + {4'd0, row_ff});
   assign row_base = 8'({py, {CB{1'b0}}});
   assign sh_wide  = {sprite_ff, 8'h00} >> shft;
   assign left_m   = sh_wide[15:8];
   assign right_m  = sh_wide[7:0];

   // memory read address
   always_comb begin
      unique case (state_ff)
         ST_FETCH_LO: mem_ra = pc_ff + 1'b1;
         ST_ROW_RD:   mem_ra = idx_ff + AW'(row_ff);
         default:     mem_ra = pc_ff;
      endcase
   end
   assign mem_we = (state_ff == ST_DECODE) && (req_ff.func == FUNC_WRITE);

   // frame port control
   always_comb begin
      fb_we = 1'b0;
      fb_wa = row_base + 8'(col);
      fb_wd = fbyte_ff ^ left_m;
      fb_ra = row_base + 8'(col);
      unique case (state_ff)
         ST_CLEAR: begin
            fb_we = 1'b1;
            fb_wa = clr_ff[7:0];
            fb_wd = 8'h00;
         end
         ST_DECODE:   fb_ra = req_ff.address[7:0];
         // write the left byte, prefetch the right one
         ST_LEFT_WR: begin
            fb_we = 1'b1;
            fb_ra = row_base + 8'(ncol);
         end
         ST_RIGHT_RD: fb_ra = row_base + 8'(ncol);
         ST_RIGHT_WR: begin
            fb_we = 1'b1;
            fb_wa = row_base + 8'(ncol);
            fb_wd = fbyte_ff ^ right_m;
         end
         default: ;
      endcase
      // clear the frame alongside the boot sweep
      if (!boot_ff[AW]) begin
         fb_we = 1'b1;
         fb_wa = boot_ff[7:0];
         fb_wd = 8'h00;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_valid && boot_ff[AW]) begin
               state_in = (req_data.func == FUNC_EXEC) ? ST_FETCH_HI : ST_DECODE;
            end
         ST_FETCH_HI: state_in = ST_FETCH_LO;
         ST_FETCH_LO: state_in = ST_DECODE;
         ST_DECODE:
            if (req_ff.func != FUNC_EXEC) state_in = ST_DONE;
            else if (op_now == OP_CLS) state_in = ST_CLEAR;
            else if (op_now[15:12] == GRP_DRW && op_now[3:0] != 4'd0)
               state_in = ST_ROW_RD;
            else state_in = ST_DONE;
         ST_CLEAR:    if (clr_ff == (FW+1)'(RB * SCREEN_HEIGHT - 1)) state_in = ST_DONE;
         ST_ROW_RD:   state_in = ST_ROW_WAIT;
         ST_ROW_WAIT: state_in = ST_LEFT_RD;
         ST_LEFT_RD:  state_in = ST_LEFT_WR;
         ST_LEFT_WR:
            if (shft != 3'd0) state_in = ST_RIGHT_RD;
            else if (row_ff == op_ff[3:0] - 4'd1) state_in = ST_DONE;
            else state_in = ST_ROW_RD;
         ST_RIGHT_RD: state_in = ST_RIGHT_WR;
         ST_RIGHT_WR:
            if (row_ff == op_ff[3:0] - 4'd1) state_in = ST_DONE;
            else state_in = ST_ROW_RD;
         ST_DONE:     if (!rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // boot sweep count mirrors the memory fill
   always_ff @(posedge clock) begin
      if (reset) boot_ff <= '0;
      else if (!boot_ff[AW]) boot_ff <= boot_ff + 1'b1;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= AW'(PC_RESET);
         idx_ff <= '0;
         for (int i = 0; i < 16; i++) vreg_ff[i] <= 8'h00;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && boot_ff[AW]) req_ff <= req_data;
               coll_ff <= 1'b0;
               unk_ff  <= 1'b0;
               hit_ff  <= 1'b0;
               row_ff  <= '0;
               clr_ff  <= '0;
            end
            ST_FETCH_LO: op_ff[15:8] <= mem_rd;
            ST_DECODE: begin
               if (req_ff.func == FUNC_EXEC) begin
                  op_ff[7:0] <= mem_rd;
               end
            end
            default: ;
         endcase
         // execute: advance or jump, then the register effect
         if (state_ff == ST_DECODE && req_ff.func == FUNC_EXEC) begin
            pc_ff <= (op_now[15:12] == GRP_JP) ? op_now[AW-1:0] : pc_ff + AW'(2);
            unique case (op_now[15:12])
               GRP_SYS: if (op_now != OP_CLS) unk_ff <= 1'b1;
               GRP_JP:  ;
               GRP_LD:  vreg_ff[op_now[11:8]] <= op_now[7:0];
               GRP_ADD: vreg_ff[op_now[11:8]] <= 8'(vreg_ff[op_now[11:8]] + op_now[7:0]);
               GRP_LDI: idx_ff <= op_now[AW-1:0];
               GRP_DRW: if (op_now[3:0] == 4'd0) vreg_ff[15] <= 8'h00;
               default: unk_ff <= 1'b1;
            endcase
         end
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_ROW_WAIT) sprite_ff <= mem_rd;
         if (state_ff == ST_LEFT_WR || state_ff == ST_RIGHT_WR) fbyte_ff <= fb_rd;
         if (state_ff == ST_LEFT_RD) fbyte_ff <= fb_rd;
         if (state_ff == ST_RIGHT_RD) fbyte_ff <= fb_rd;
         if (state_ff == ST_LEFT_WR && (fbyte_ff & left_m) != 8'h00) hit_ff <= 1'b1;
         if (state_ff == ST_RIGHT_WR && (fbyte_ff & right_m) != 8'h00) hit_ff <= 1'b1;
         if ((state_ff == ST_LEFT_WR && shft == 3'd0) || state_ff == ST_RIGHT_WR) begin
            row_ff <= row_ff + 4'd1;
            if (row_ff == op_ff[3:0] - 4'd1) begin
               vreg_ff[15] <= {7'd0, hit_ff | (state_ff == ST_LEFT_WR ?
                  |(fbyte_ff & left_m) : |(fbyte_ff & right_m))};
               coll_ff <= hit_ff | (state_ff == ST_LEFT_WR ?
                  |(fbyte_ff & left_m) : |(fbyte_ff & right_m));
            end
         end
      end
   end

   // the frame read issued in decode lands on entry to done
   logic [7:0] rd_hold_ff;
   logic       first_done_ff;
   always_ff @(posedge clock) begin
      first_done_ff <= (state_ff == ST_DECODE);
      if (first_done_ff) rd_hold_ff <= fb_rd;
   end

   assign req_stall = (state_ff != ST_IDLE) || !boot_ff[AW];
   assign rsp_valid = (state_ff == ST_DONE);
   always_comb begin
      rsp_data.read_data = (req_ff.func == FUNC_READ) ?
                           (first_done_ff ? fb_rd : rd_hold_ff) : 8'h00;
      rsp_data.program_counter = 12'(pc_ff);
      rsp_data.collision = coll_ff;
      rsp_data.unknown_opcode = unk_ff;
   end
endmodule
`default_nettype wire
